FILE: rtl/srt_pkg.sv
// ---------------------------------------------------------------------------
// srt_pkg - shared types and constants of the sector remap table
// Request and result structs, field codes and the controller command and
// status groups.
// ---------------------------------------------------------------------------
package srt_pkg;

  localparam int SECTOR_W    = 48;
  localparam int NUM_SLOTS   = 1024;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int COUNT_W     = 11;
  localparam int GEN_W       = 32;
  localparam int TOTAL_W     = 64;

  // request kind
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // result status
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_DUP  = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [SECTOR_W-1:0] bad_lba;
    logic [SECTOR_W-1:0] spare_lba;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [SECTOR_W-1:0] spare_out;
    logic [COUNT_W-1:0]  entries_used;
    logic [GEN_W-1:0]    generation_out;
  } res_t;

  // which result the datapath registers this cycle
  typedef enum logic [2:0] {
    RES_NONE,
    RES_FULL,
    RES_DUP,
    RES_HIT,
    RES_MISS,
    RES_ADDED
  } res_sel_t;

  typedef struct packed {
    logic     load;    // take the request beat
    logic     issue;   // read the next stored entry
    logic     commit;  // append the pair and bump the counters
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic match;    // the entry read last cycle holds the key
    logic pend;     // a read is in flight
    logic more_rd;  // filled entries remain to be read
  } stat_t;

endpackage

FILE: rtl/srt_ram.sv
// ---------------------------------------------------------------------------
// srt_ram - generic single-port RAM
// One write or one read per cycle; read data is registered and held.
// ---------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/srt_ctrl.sv
// ---------------------------------------------------------------------------
// srt_ctrl - request sequencer of the sector remap table
// Takes a request, walks the filled entries and picks the result.
// ---------------------------------------------------------------------------
module srt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  srt_pkg::stat_t stat,
  output srt_pkg::cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.issue   = 1'b0;
    cmd.commit  = 1'b0;
    cmd.res_sel = srt_pkg::RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.kind == srt_pkg::KIND_ADD && stat.full) begin
          cmd.res_sel = srt_pkg::RES_FULL;
          state_nxt   = S_IDLE;
        end else if (stat.match) begin
          cmd.res_sel = (stat.kind == srt_pkg::KIND_ADD) ? srt_pkg::RES_DUP
                                                          : srt_pkg::RES_HIT;
          state_nxt   = S_IDLE;
        end else if (!stat.pend && !stat.more_rd) begin
          // whole table read without a hit
          if (stat.kind == srt_pkg::KIND_ADD) begin
            cmd.commit  = 1'b1;
            cmd.res_sel = srt_pkg::RES_ADDED;
          end else begin
            cmd.res_sel = srt_pkg::RES_MISS;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.issue = stat.more_rd;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/srt_dp.sv
// ---------------------------------------------------------------------------
// srt_dp - datapath of the sector remap table
// Entry stores, scan pointer, key compare, counters and the result register.
// ---------------------------------------------------------------------------
module srt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  srt_pkg::req_t  in_req,
  input  srt_pkg::cmd_t  cmd,
  output srt_pkg::stat_t stat,
  output logic           out_valid,
  output srt_pkg::res_t  out_res
);

  srt_pkg::req_t                  req_r;
  logic [srt_pkg::COUNT_W-1:0]    used_r;
  logic [srt_pkg::COUNT_W-1:0]    rd_idx_r;
  logic                           pend_r;
  logic [srt_pkg::GEN_W-1:0]      gen_r;
  logic [srt_pkg::TOTAL_W-1:0]    total_r;
  logic                           dirty_r;
  logic                           out_valid_r;
  srt_pkg::res_t                  out_r;
  srt_pkg::res_t                  out_nxt;

  logic                           more_rd;
  logic                           rd_en;
  logic                           match;
  logic [srt_pkg::IDX_W-1:0]      addr;
  logic [srt_pkg::SECTOR_W-1:0]   main_rdata;
  logic [srt_pkg::SECTOR_W-1:0]   spare_rdata;
  logic [srt_pkg::COUNT_W-1:0]    used_inc;
  logic [srt_pkg::GEN_W-1:0]      gen_inc;

  assign more_rd  = (rd_idx_r < used_r);
  assign rd_en    = cmd.issue && more_rd;
  assign match    = pend_r && (main_rdata == req_r.bad_lba);
  assign addr     = cmd.commit ? used_r[srt_pkg::IDX_W-1:0] : rd_idx_r[srt_pkg::IDX_W-1:0];
  assign used_inc = used_r + 1'b1;
  assign gen_inc  = gen_r + 1'b1;

  srt_ram #(
    .WIDTH(srt_pkg::SECTOR_W),
    .DEPTH(srt_pkg::NUM_SLOTS)
  ) u_main_ram (
    .clk  (clk),
    .we   (cmd.commit),
    .re   (rd_en),
    .addr (addr),
    .wdata(req_r.bad_lba),
    .rdata(main_rdata)
  );

  srt_ram #(
    .WIDTH(srt_pkg::SECTOR_W),
    .DEPTH(srt_pkg::NUM_SLOTS)
  ) u_spare_ram (
    .clk  (clk),
    .we   (cmd.commit),
    .re   (rd_en),
    .addr (addr),
    .wdata(req_r.spare_lba),
    .rdata(spare_rdata)
  );

  assign stat.kind    = req_r.kind;
  assign stat.full    = (used_r == srt_pkg::COUNT_W'(srt_pkg::NUM_SLOTS));
  assign stat.match   = match;
  assign stat.pend    = pend_r;
  assign stat.more_rd = more_rd;

  always_comb begin
    out_nxt.status         = srt_pkg::STAT_OK;
    out_nxt.found          = 1'b0;
    out_nxt.spare_out      = '0;
    out_nxt.entries_used   = used_r;
    out_nxt.generation_out = gen_r;
    case (cmd.res_sel)
      srt_pkg::RES_FULL: out_nxt.status = srt_pkg::STAT_FULL;
      srt_pkg::RES_DUP:  out_nxt.status = srt_pkg::STAT_DUP;
      srt_pkg::RES_HIT: begin
        out_nxt.found     = 1'b1;
        out_nxt.spare_out = spare_rdata;
      end
      srt_pkg::RES_ADDED: begin
        out_nxt.entries_used   = used_inc;
        out_nxt.generation_out = gen_inc;
      end
      default: ;
    endcase
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.res_sel != srt_pkg::RES_NONE) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      gen_r       <= '0;
      total_r     <= '0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.res_sel != srt_pkg::RES_NONE);
      if (cmd.load) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
      end else begin
        pend_r <= rd_en;
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        used_r  <= used_inc;
        gen_r   <= gen_inc;
        total_r <= total_r + 1'b1;
        dirty_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

FILE: rtl/sector_remap_table_core.sv
// ---------------------------------------------------------------------------
// sector_remap_table_core - bad-sector remap table
// Appends (bad, spare) sector pairs and answers lookups by bad sector.
// ---------------------------------------------------------------------------
//   channel   handshake          payload
//   request   start / busy       in_req  (kind, bad_lba, spare_lba)
//   result    out_valid strobe   out_res (status, found, spare_out,
//                                         entries_used, generation_out)
//
// A request is taken when start is high and busy low. It walks the filled
// entries one RAM read a cycle; an add to a full table answers without a
// scan. The result beat shows for one cycle and cannot be held off; the
// next request may be taken in that cycle.
// Synchronous active-low reset empties the table; no clearing pass runs.
// ---------------------------------------------------------------------------
module sector_remap_table_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  srt_pkg::req_t in_req,
  output logic          out_valid,
  output srt_pkg::res_t out_res
);

  srt_pkg::cmd_t  cmd;
  srt_pkg::stat_t stat;

  srt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  srt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule
